### design/lock_order_cycle_checker_unit_assert.svh
// Assertion macros used by the lock order cycle checker unit.
`ifndef LOCK_ORDER_CYCLE_CHECKER_UNIT_ASSERT_SVH
`define LOCK_ORDER_CYCLE_CHECKER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LOCC_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lock order checker assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LOCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lock order checker assertion failed");

`endif

### design/locc_pkg.sv
// Package with the types and codes of the lock order cycle checker.
`timescale 1ns / 1ps

package locc_pkg;

    localparam int ADDR_W = 64;
    localparam int HELD_AFTER_W = 5;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_RECURSIVE = 3'd2,
        ST_CYCLE     = 3'd3,
        ST_UNHELD    = 3'd4
    } status_t;

    typedef enum logic {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef struct packed {
        op_t               operation;
        logic [1:0]        core;
        logic [ADDR_W-1:0] lock_address;
    } lock_item_t;

    typedef struct packed {
        status_t                 status;
        logic [ADDR_W-1:0]       conflict_address;
        logic [HELD_AFTER_W-1:0] held_after;
    } verdict_item_t;

    typedef struct packed {
        logic              start;
        logic [ADDR_W-1:0] key;
    } node_req_t;

    typedef struct packed {
        logic done;
        logic found;
        logic fresh;
    } node_resp_t;

    typedef enum logic [1:0] {
        NT_IDLE,
        NT_READ,
        NT_COMPARE
    } node_state_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_REC_RD,
        S_REC_CHK,
        S_FRESH_GO,
        S_FRESH_LOOK,
        S_FRESH_CLR,
        S_FRESH_RD,
        S_FRESH_WAIT,
        S_HELD_RD,
        S_HELD_WAIT,
        S_HELD_GO,
        S_HELD_LOOK,
        S_HELD_CLR,
        S_HELD_CHECK,
        S_HROW_RD,
        S_HROW_CHK,
        S_X_RD,
        S_X_CHK,
        S_HELD_NEXT,
        S_PUSH,
        S_REL_RD,
        S_REL_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_POP,
        S_DONE
    } seq_state_t;

endpackage

### design/locc_ram.sv
// Simple dual-port memory with one write port and one registered read port.
`timescale 1ns / 1ps

module locc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/locc_node_table.sv
// Lock address table with a sequential search that allocates unknown addresses.
`timescale 1ns / 1ps

module locc_node_table #(
    parameter int NODE_LIMIT = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  locc_pkg::node_req_t               req,
    output locc_pkg::node_resp_t              resp,
    output logic [$clog2(NODE_LIMIT)-1:0]     node_idx,
    output logic [$clog2(NODE_LIMIT+1)-1:0]   node_total
);

    localparam int NW  = $clog2(NODE_LIMIT);
    localparam int NCW = $clog2(NODE_LIMIT + 1);

    locc_pkg::node_state_t          state_reg, state_next;
    logic [NCW-1:0]                 j_reg, j_next;
    logic [NCW-1:0]                 total_reg, total_next;
    logic [locc_pkg::ADDR_W-1:0]    key_reg, key_next;
    locc_pkg::node_resp_t           resp_reg, resp_next;
    logic [NW-1:0]                  idx_reg, idx_next;
    logic                           mem_wr;
    logic                           mem_rd;
    logic [locc_pkg::ADDR_W-1:0]    mem_rd_data;

    locc_ram #(
        .WIDTH(locc_pkg::ADDR_W),
        .DEPTH(NODE_LIMIT)
    ) u_addr_ram (
        .clk    (clk),
        .wr_en  (mem_wr),
        .wr_addr(NW'(total_reg)),
        .wr_data(key_reg),
        .rd_en  (mem_rd),
        .rd_addr(NW'(j_reg)),
        .rd_data(mem_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= locc_pkg::NT_IDLE;
            j_reg     <= '0;
            total_reg <= '0;
            resp_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            total_reg <= total_next;
            resp_reg  <= resp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        idx_reg <= idx_next;
    end

    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        total_next = total_reg;
        key_next   = key_reg;
        idx_next   = idx_reg;
        resp_next  = '{done: 1'b0, found: resp_reg.found, fresh: resp_reg.fresh};
        mem_wr     = 1'b0;
        mem_rd     = 1'b0;
        unique case (state_reg)
            locc_pkg::NT_IDLE:
            begin
                if (req.start)
                begin
                    key_next   = req.key;
                    j_next     = '0;
                    state_next = locc_pkg::NT_READ;
                end
            end
            locc_pkg::NT_READ:
            begin
                if (j_reg >= total_reg)
                begin
                    if (total_reg < NCW'(NODE_LIMIT))
                    begin
                        mem_wr     = 1'b1;
                        idx_next   = NW'(total_reg);
                        total_next = total_reg + NCW'(1);
                        resp_next  = '{done: 1'b1, found: 1'b1, fresh: 1'b1};
                    end
                    else
                    begin
                        resp_next = '{done: 1'b1, found: 1'b0, fresh: 1'b0};
                    end
                    state_next = locc_pkg::NT_IDLE;
                end
                else
                begin
                    mem_rd     = 1'b1;
                    state_next = locc_pkg::NT_COMPARE;
                end
            end
            locc_pkg::NT_COMPARE:
            begin
                if (mem_rd_data == key_reg)
                begin
                    idx_next   = NW'(j_reg);
                    resp_next  = '{done: 1'b1, found: 1'b1, fresh: 1'b0};
                    state_next = locc_pkg::NT_IDLE;
                end
                else
                begin
                    j_next     = j_reg + NCW'(1);
                    state_next = locc_pkg::NT_READ;
                end
            end
            default:
            begin
                state_next = locc_pkg::NT_IDLE;
            end
        endcase
    end

    assign resp       = resp_reg;
    assign node_idx   = idx_reg;
    assign node_total = total_reg;

endmodule

### design/lock_order_cycle_checker_unit.sv
// Lock order cycle checker: sequencer, held stacks and closure matrix.
`timescale 1ns / 1ps

// Each transaction is worked on alone. An acquire with locks held first scans the held
// stack for recursion, then searches the node table for the new lock and again for each
// held lock, and for every new ordering edge sweeps all known locks through the order
// matrix, one row at a time. A release scans stack entries from the top and shifts the
// entries above the released one down. The node table, the order matrix and the held
// stacks each have a single read port. No clearing pass is needed after reset; matrix
// rows are cleared as nodes are allocated.
`include "lock_order_cycle_checker_unit_assert.svh"

module lock_order_cycle_checker_unit #(
    parameter int HELD_DEPTH = 16,
    parameter int NODE_LIMIT = 256,
    parameter int CORE_TOTAL = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    lock_valid,
    output logic                    lock_stall,
    input  locc_pkg::lock_item_t    lock_item,
    output logic                    verdict_valid,
    input  logic                    verdict_stall,
    output locc_pkg::verdict_item_t verdict_item
);

    localparam int CNW = $clog2(HELD_DEPTH + 1);
    localparam int CIW = (CORE_TOTAL > 1) ? $clog2(CORE_TOTAL) : 1;
    localparam int HSD = CORE_TOTAL * HELD_DEPTH;
    localparam int HAW = (HSD > 1) ? $clog2(HSD) : 1;
    localparam int NW  = $clog2(NODE_LIMIT);
    localparam int NCW = $clog2(NODE_LIMIT + 1);

    locc_pkg::seq_state_t        state_reg, state_next;
    logic [CIW-1:0]              core_idx_reg, core_idx_next;
    logic [HAW-1:0]              base_reg, base_next;
    logic [locc_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [CNW-1:0]              count_reg, count_next;
    logic [CNW-1:0]              idx_reg, idx_next;
    logic [NW-1:0]               fresh_reg, fresh_next;
    logic [NW-1:0]               held_reg, held_next;
    logic [NODE_LIMIT-1:0]       fresh_row_reg, fresh_row_next;
    logic [locc_pkg::ADDR_W-1:0] haddr_reg, haddr_next;
    logic [NCW-1:0]              x_reg, x_next;
    locc_pkg::status_t           status_reg, status_next;
    logic [locc_pkg::ADDR_W-1:0] conflict_reg, conflict_next;
    logic [CNW-1:0]              counts_reg [CORE_TOTAL];
    logic                        counts_wr;
    logic [CNW-1:0]              counts_wr_data;
    logic                        verdict_valid_reg, verdict_valid_next;
    locc_pkg::verdict_item_t     verdict_reg, verdict_next;

    logic                        core_ok;
    logic [CIW-1:0]              core_sel;
    logic [CNW-1:0]              cnt_in;

    logic                        hs_wr;
    logic [HAW-1:0]              hs_wr_addr;
    logic [locc_pkg::ADDR_W-1:0] hs_wr_data;
    logic                        hs_rd;
    logic [HAW-1:0]              hs_rd_addr;
    logic [locc_pkg::ADDR_W-1:0] hs_rd_data;

    logic                        mx_wr;
    logic [NW-1:0]               mx_wr_addr;
    logic [NODE_LIMIT-1:0]       mx_wr_data;
    logic                        mx_rd;
    logic [NW-1:0]               mx_rd_addr;
    logic [NODE_LIMIT-1:0]       mx_rd_data;

    locc_pkg::node_req_t         node_req;
    locc_pkg::node_resp_t        node_resp;
    logic [NW-1:0]               node_idx;
    logic [NCW-1:0]              node_total;

    locc_ram #(
        .WIDTH(locc_pkg::ADDR_W),
        .DEPTH(HSD)
    ) u_held_ram (
        .clk    (clk),
        .wr_en  (hs_wr),
        .wr_addr(hs_wr_addr),
        .wr_data(hs_wr_data),
        .rd_en  (hs_rd),
        .rd_addr(hs_rd_addr),
        .rd_data(hs_rd_data)
    );

    locc_ram #(
        .WIDTH(NODE_LIMIT),
        .DEPTH(NODE_LIMIT)
    ) u_matrix_ram (
        .clk    (clk),
        .wr_en  (mx_wr),
        .wr_addr(mx_wr_addr),
        .wr_data(mx_wr_data),
        .rd_en  (mx_rd),
        .rd_addr(mx_rd_addr),
        .rd_data(mx_rd_data)
    );

    locc_node_table #(
        .NODE_LIMIT(NODE_LIMIT)
    ) u_node_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (node_req),
        .resp      (node_resp),
        .node_idx  (node_idx),
        .node_total(node_total)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= locc_pkg::S_IDLE;
            verdict_valid_reg <= 1'b0;
            for (int c = 0; c < CORE_TOTAL; c++)
            begin
                counts_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg         <= state_next;
            verdict_valid_reg <= verdict_valid_next;
            if (counts_wr)
            begin
                counts_reg[core_idx_reg] <= counts_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        core_idx_reg  <= core_idx_next;
        base_reg      <= base_next;
        addr_reg      <= addr_next;
        count_reg     <= count_next;
        idx_reg       <= idx_next;
        fresh_reg     <= fresh_next;
        held_reg      <= held_next;
        fresh_row_reg <= fresh_row_next;
        haddr_reg     <= haddr_next;
        x_reg         <= x_next;
        status_reg    <= status_next;
        conflict_reg  <= conflict_next;
        verdict_reg   <= verdict_next;
    end

    assign core_ok  = {30'd0, lock_item.core} < 32'(CORE_TOTAL);
    assign core_sel = CIW'(lock_item.core);
    assign cnt_in   = core_ok ? counts_reg[core_sel] : '0;

    always_comb
    begin
        state_next         = state_reg;
        core_idx_next      = core_idx_reg;
        base_next          = base_reg;
        addr_next          = addr_reg;
        count_next         = count_reg;
        idx_next           = idx_reg;
        fresh_next         = fresh_reg;
        held_next          = held_reg;
        fresh_row_next     = fresh_row_reg;
        haddr_next         = haddr_reg;
        x_next             = x_reg;
        status_next        = status_reg;
        conflict_next      = conflict_reg;
        verdict_next       = verdict_reg;
        verdict_valid_next = verdict_valid_reg && verdict_stall;
        counts_wr          = 1'b0;
        counts_wr_data     = count_reg;
        hs_wr              = 1'b0;
        hs_wr_addr         = base_reg + HAW'(idx_reg);
        hs_wr_data         = hs_rd_data;
        hs_rd              = 1'b0;
        hs_rd_addr         = base_reg + HAW'(idx_reg);
        mx_wr              = 1'b0;
        mx_wr_addr         = fresh_reg;
        mx_wr_data         = '0;
        mx_rd              = 1'b0;
        mx_rd_addr         = fresh_reg;
        node_req           = '{start: 1'b0, key: addr_reg};
        lock_stall         = (state_reg != locc_pkg::S_IDLE);
        unique case (state_reg)
            locc_pkg::S_IDLE:
            begin
                if (lock_valid)
                begin
                    addr_next     = lock_item.lock_address;
                    core_idx_next = core_sel;
                    base_next     = HAW'(core_sel) * HAW'(HELD_DEPTH);
                    count_next    = cnt_in;
                    idx_next      = '0;
                    status_next   = locc_pkg::ST_OK;
                    conflict_next = '0;
                    if (!core_ok)
                    begin
                        count_next = '0;
                        state_next = locc_pkg::S_DONE;
                    end
                    else if (lock_item.operation == locc_pkg::OP_ACQUIRE)
                    begin
                        if (cnt_in >= CNW'(HELD_DEPTH))
                        begin
                            status_next = locc_pkg::ST_FULL;
                            state_next  = locc_pkg::S_DONE;
                        end
                        else if (cnt_in == '0)
                        begin
                            state_next = locc_pkg::S_FRESH_GO;
                        end
                        else
                        begin
                            state_next = locc_pkg::S_REC_RD;
                        end
                    end
                    else
                    begin
                        if (cnt_in == '0)
                        begin
                            status_next = locc_pkg::ST_UNHELD;
                            state_next  = locc_pkg::S_DONE;
                        end
                        else
                        begin
                            idx_next   = cnt_in;
                            state_next = locc_pkg::S_REL_RD;
                        end
                    end
                end
            end
            locc_pkg::S_REC_RD:
            begin
                hs_rd      = 1'b1;
                state_next = locc_pkg::S_REC_CHK;
            end
            locc_pkg::S_REC_CHK:
            begin
                if (hs_rd_data == addr_reg)
                begin
                    status_next = locc_pkg::ST_RECURSIVE;
                    state_next  = locc_pkg::S_DONE;
                end
                else if (idx_reg + CNW'(1) == count_reg)
                begin
                    state_next = locc_pkg::S_FRESH_GO;
                end
                else
                begin
                    idx_next   = idx_reg + CNW'(1);
                    state_next = locc_pkg::S_REC_RD;
                end
            end
            locc_pkg::S_FRESH_GO:
            begin
                node_req   = '{start: 1'b1, key: addr_reg};
                state_next = locc_pkg::S_FRESH_LOOK;
            end
            locc_pkg::S_FRESH_LOOK:
            begin
                if (node_resp.done)
                begin
                    if (!node_resp.found)
                    begin
                        state_next = locc_pkg::S_PUSH;
                    end
                    else
                    begin
                        fresh_next = node_idx;
                        state_next = node_resp.fresh ? locc_pkg::S_FRESH_CLR
                                                     : locc_pkg::S_FRESH_RD;
                    end
                end
            end
            locc_pkg::S_FRESH_CLR:
            begin
                mx_wr      = 1'b1;
                mx_wr_addr = fresh_reg;
                mx_wr_data = '0;
                state_next = locc_pkg::S_FRESH_RD;
            end
            locc_pkg::S_FRESH_RD:
            begin
                mx_rd      = 1'b1;
                mx_rd_addr = fresh_reg;
                state_next = locc_pkg::S_FRESH_WAIT;
            end
            locc_pkg::S_FRESH_WAIT:
            begin
                fresh_row_next = mx_rd_data;
                idx_next       = '0;
                state_next     = (count_reg == '0) ? locc_pkg::S_PUSH : locc_pkg::S_HELD_RD;
            end
            locc_pkg::S_HELD_RD:
            begin
                hs_rd      = 1'b1;
                state_next = locc_pkg::S_HELD_WAIT;
            end
            locc_pkg::S_HELD_WAIT:
            begin
                haddr_next = hs_rd_data;
                state_next = locc_pkg::S_HELD_GO;
            end
            locc_pkg::S_HELD_GO:
            begin
                node_req   = '{start: 1'b1, key: haddr_reg};
                state_next = locc_pkg::S_HELD_LOOK;
            end
            locc_pkg::S_HELD_LOOK:
            begin
                if (node_resp.done)
                begin
                    if (!node_resp.found)
                    begin
                        state_next = locc_pkg::S_HELD_NEXT;
                    end
                    else
                    begin
                        held_next  = node_idx;
                        state_next = node_resp.fresh ? locc_pkg::S_HELD_CLR
                                                     : locc_pkg::S_HELD_CHECK;
                    end
                end
            end
            locc_pkg::S_HELD_CLR:
            begin
                mx_wr      = 1'b1;
                mx_wr_addr = held_reg;
                mx_wr_data = '0;
                state_next = locc_pkg::S_HELD_CHECK;
            end
            locc_pkg::S_HELD_CHECK:
            begin
                if (fresh_row_reg[held_reg])
                begin
                    status_next   = locc_pkg::ST_CYCLE;
                    conflict_next = haddr_reg;
                    state_next    = locc_pkg::S_DONE;
                end
                else
                begin
                    state_next = locc_pkg::S_HROW_RD;
                end
            end
            locc_pkg::S_HROW_RD:
            begin
                mx_rd      = 1'b1;
                mx_rd_addr = held_reg;
                state_next = locc_pkg::S_HROW_CHK;
            end
            locc_pkg::S_HROW_CHK:
            begin
                if (mx_rd_data[fresh_reg])
                begin
                    state_next = locc_pkg::S_HELD_NEXT;
                end
                else
                begin
                    x_next     = '0;
                    state_next = locc_pkg::S_X_RD;
                end
            end
            locc_pkg::S_X_RD:
            begin
                mx_rd      = 1'b1;
                mx_rd_addr = NW'(x_reg);
                state_next = locc_pkg::S_X_CHK;
            end
            locc_pkg::S_X_CHK:
            begin
                // Every lock ordered before the held one, and the held one itself, now
                // precedes the new lock and everything the new lock precedes.
                if ((NW'(x_reg) == held_reg) || mx_rd_data[held_reg])
                begin
                    mx_wr      = 1'b1;
                    mx_wr_addr = NW'(x_reg);
                    mx_wr_data = mx_rd_data | fresh_row_reg
                                 | (NODE_LIMIT'(1) << fresh_reg);
                end
                if (x_reg + NCW'(1) >= node_total)
                begin
                    state_next = locc_pkg::S_HELD_NEXT;
                end
                else
                begin
                    x_next     = x_reg + NCW'(1);
                    state_next = locc_pkg::S_X_RD;
                end
            end
            locc_pkg::S_HELD_NEXT:
            begin
                if (idx_reg + CNW'(1) == count_reg)
                begin
                    state_next = locc_pkg::S_PUSH;
                end
                else
                begin
                    idx_next   = idx_reg + CNW'(1);
                    state_next = locc_pkg::S_HELD_RD;
                end
            end
            locc_pkg::S_PUSH:
            begin
                hs_wr          = 1'b1;
                hs_wr_addr     = base_reg + HAW'(count_reg);
                hs_wr_data     = addr_reg;
                counts_wr      = 1'b1;
                counts_wr_data = count_reg + CNW'(1);
                count_next     = count_reg + CNW'(1);
                status_next    = locc_pkg::ST_OK;
                state_next     = locc_pkg::S_DONE;
            end
            locc_pkg::S_REL_RD:
            begin
                hs_rd      = 1'b1;
                hs_rd_addr = base_reg + HAW'(idx_reg - CNW'(1));
                state_next = locc_pkg::S_REL_CHK;
            end
            locc_pkg::S_REL_CHK:
            begin
                if (hs_rd_data == addr_reg)
                begin
                    idx_next   = idx_reg - CNW'(1);
                    state_next = (idx_reg == count_reg) ? locc_pkg::S_POP
                                                        : locc_pkg::S_SHIFT_RD;
                end
                else if (idx_reg == CNW'(1))
                begin
                    status_next = locc_pkg::ST_UNHELD;
                    state_next  = locc_pkg::S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg - CNW'(1);
                    state_next = locc_pkg::S_REL_RD;
                end
            end
            locc_pkg::S_SHIFT_RD:
            begin
                hs_rd      = 1'b1;
                hs_rd_addr = base_reg + HAW'(idx_reg + CNW'(1));
                state_next = locc_pkg::S_SHIFT_WR;
            end
            locc_pkg::S_SHIFT_WR:
            begin
                hs_wr      = 1'b1;
                hs_wr_addr = base_reg + HAW'(idx_reg);
                hs_wr_data = hs_rd_data;
                if (idx_reg + CNW'(1) == count_reg - CNW'(1))
                begin
                    state_next = locc_pkg::S_POP;
                end
                else
                begin
                    idx_next   = idx_reg + CNW'(1);
                    state_next = locc_pkg::S_SHIFT_RD;
                end
            end
            locc_pkg::S_POP:
            begin
                counts_wr      = 1'b1;
                counts_wr_data = count_reg - CNW'(1);
                count_next     = count_reg - CNW'(1);
                status_next    = locc_pkg::ST_OK;
                state_next     = locc_pkg::S_DONE;
            end
            locc_pkg::S_DONE:
            begin
                if (!verdict_valid_reg || !verdict_stall)
                begin
                    verdict_next.status           = status_reg;
                    verdict_next.conflict_address = conflict_reg;
                    verdict_next.held_after       = locc_pkg::HELD_AFTER_W'(count_reg);
                    verdict_valid_next            = 1'b1;
                    state_next                    = locc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = locc_pkg::S_IDLE;
            end
        endcase
    end

    assign verdict_valid = verdict_valid_reg;
    assign verdict_item  = verdict_reg;

    `LOCC_ASSERT_NEXT(a_accept_leaves_idle,
        lock_valid && !lock_stall,
        state_reg != locc_pkg::S_IDLE)
    `LOCC_ASSERT_IMPLIES(a_push_in_range,
        state_reg == locc_pkg::S_PUSH,
        count_reg < CNW'(HELD_DEPTH))
    `LOCC_ASSERT_IMPLIES(a_conflict_only_on_cycle,
        verdict_valid_reg && (verdict_reg.status != locc_pkg::ST_CYCLE),
        verdict_reg.conflict_address == '0)

endmodule
